>>> src/affsa_pkg.sv
`timescale 1ns / 1ps
package affsa_pkg;

  localparam int ADDR_BITS         = 16;
  localparam int FREE_ENTRIES_DEF  = 16;
  localparam logic [ADDR_BITS-1:0] CAPACITY_RESET = '1;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_HIGH  = 2'd2;
  localparam logic [1:0] REQ_RESET = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
  localparam logic [2:0] ST_BAD_ALIGN  = 3'd2;
  localparam logic [2:0] ST_BOGUS_FREE = 3'd3;
  localparam logic [2:0] ST_NO_SPACE   = 3'd4;
  localparam logic [2:0] ST_TABLE_FULL = 3'd5;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [ADDR_BITS-1:0] block_size;
    logic [ADDR_BITS-1:0] align;
    logic [ADDR_BITS-1:0] location;
  } req_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] offset;
    logic [2:0]           status;
    logic [ADDR_BITS-1:0] segment_top;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] length;
  } ent_t;

endpackage

>>> src/affsa_rem.sv
`timescale 1ns / 1ps
// Restoring remainder unit, one quotient bit per cycle.
module affsa_rem (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [affsa_pkg::ADDR_BITS-1:0] dividend,
  input  logic [affsa_pkg::ADDR_BITS-1:0] divisor,
  output logic                            done,
  output logic [affsa_pkg::ADDR_BITS-1:0] rem
);
  import affsa_pkg::*;

  localparam int CW = $clog2(ADDR_BITS);

  logic           busy;
  logic [CW-1:0]  cnt;
  logic [ADDR_BITS-1:0] dvd;
  logic [ADDR_BITS-1:0] dsr;
  logic [ADDR_BITS:0]   trial;
  logic [ADDR_BITS-1:0] rem_next;

  assign trial    = {rem, dvd[ADDR_BITS-1]};
  assign rem_next = (trial >= {1'b0, dsr}) ? ADDR_BITS'(trial - {1'b0, dsr})
                                          : trial[ADDR_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[ADDR_BITS-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(ADDR_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> src/aligned_first_fit_segment_allocator.sv
`timescale 1ns / 1ps
// Aligned first-fit segment allocator. One request beat in, one response beat
// out. Requests are taken one at a time; req_stall is high from acceptance until
// the response is loaded into the output register. A reset request or an
// argument error goes straight to the response. A first-fit allocation reads
// each free extent scanned, works out its alignment padding in the shared
// bit-serial remainder unit and then evaluates the fit; table entries are
// moved when an extent is split or removed. A bump of the top mark adds one
// more remainder pass. A free reads each extent scanned and moves entries
// when an extent is inserted or two merge. The free-extent table is a simple
// dual-port memory (one read, one write a cycle); its entries are only read
// below the fill count, so it needs no clearing after reset.
module aligned_first_fit_segment_allocator #(
  parameter int FREE_ENTRIES = affsa_pkg::FREE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [affsa_pkg::ADDR_BITS-1:0] cfg_data,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  affsa_pkg::req_t                 req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output affsa_pkg::rsp_t                 rsp
);
  import affsa_pkg::*;

  localparam int IDX_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(FREE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(FREE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_BUMP_DIV, S_BUMP_WAIT, S_BUMP_EVAL, S_SCAN_RD, S_SCAN_DATA,
    S_FIT_WAIT, S_FIT_EVAL, S_NEXT_RD, S_NEXT_DATA, S_UP_RD, S_UP_WR,
    S_DN_RD, S_DN_WR, S_INS_WR, S_DONE
  } state_t;

  // free-extent table
  ent_t mem [FREE_ENTRIES];
  ent_t rdata;
  logic mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  ent_t mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] j, j_next;
  logic [CNT_W-1:0] ins_pos, ins_pos_next;
  ent_t ins_word, ins_word_next;
  logic [ADDR_BITS-1:0] top, top_next;
  logic [ADDR_BITS-1:0] cap;
  logic [ADDR_BITS-1:0] e_start, e_start_next;
  logic [ADDR_BITS-1:0] e_len, e_len_next;
  logic [ADDR_BITS-1:0] cur_len, cur_len_next;
  logic [ADDR_BITS:0]   mrg_end, mrg_end_next;
  logic [ADDR_BITS-1:0] res_off, res_off_next;
  logic [2:0]           res_st, res_st_next;
  req_t rq, rq_next;
  logic rsp_valid_next;
  rsp_t rsp_next;

  // shared remainder unit
  logic div_start, div_done;
  logic [ADDR_BITS-1:0] div_dvd, rem_q, pad;

  affsa_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (rq.align),
    .done     (div_done),
    .rem      (rem_q)
  );

  assign pad = (rem_q == '0) ? '0 : ADDR_BITS'(rq.align - rem_q);

  logic [ADDR_BITS:0]   need, in_end, s_end;
  logic [ADDR_BITS+1:0] ntop;

  assign need   = {1'b0, rq.block_size} + {1'b0, pad};
  assign ntop   = (ADDR_BITS+2)'(top) + (ADDR_BITS+2)'(pad) + (ADDR_BITS+2)'(rq.block_size);
  assign in_end = {1'b0, rq.location} + {1'b0, rq.block_size};
  assign s_end  = {1'b0, rdata.start} + {1'b0, rdata.length};

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    j_next         = j;
    ins_pos_next   = ins_pos;
    ins_word_next  = ins_word;
    top_next       = top;
    e_start_next   = e_start;
    e_len_next     = e_len;
    cur_len_next   = cur_len;
    mrg_end_next   = mrg_end;
    res_off_next   = res_off;
    res_st_next    = res_st;
    rq_next        = rq;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    mem_we         = 1'b0;
    mem_waddr      = idx[IDX_W-1:0];
    mem_wdata      = ins_word;
    mem_raddr      = idx[IDX_W-1:0];
    div_start      = 1'b0;
    div_dvd        = top;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          rq_next      = req;
          res_off_next = '0;
          res_st_next  = ST_OK;
          idx_next     = '0;
          state_next   = S_DONE;
          case (req.req_type)
            REQ_ALLOC: begin
              if (req.block_size == '0) res_st_next = ST_BAD_SIZE;
              else if (req.align == '0) res_st_next = ST_BAD_ALIGN;
              else state_next = S_SCAN_RD;
            end
            REQ_FREE: begin
              if (req.block_size == '0) begin
                res_st_next = ST_BAD_SIZE;
              end else if (req.location >= top ||
                           ({1'b0, req.location} + {1'b0, req.block_size}) >
                           {1'b0, top}) begin
                res_st_next = ST_BOGUS_FREE;
              end else begin
                state_next = S_SCAN_RD;
              end
            end
            REQ_HIGH: begin
              if (req.align == '0) res_st_next = ST_BAD_ALIGN;
              else state_next = S_BUMP_DIV;
            end
            default: begin
              count_next = '0;
              top_next   = '0;
            end
          endcase
        end
      end

      S_BUMP_DIV: begin
        div_start  = 1'b1;
        div_dvd    = top;
        state_next = S_BUMP_WAIT;
      end

      S_BUMP_WAIT: begin
        if (div_done) state_next = S_BUMP_EVAL;
      end

      S_BUMP_EVAL: begin
        state_next = S_DONE;
        if (ntop > (ADDR_BITS+2)'(cap)) begin
          res_st_next = ST_NO_SPACE;
        end else if (pad != '0 && count >= FULL) begin
          res_st_next = ST_TABLE_FULL;
        end else begin
          if (pad != '0) begin
            mem_we     = 1'b1;
            mem_waddr  = count[IDX_W-1:0];
            mem_wdata  = '{start: top, length: pad};
            count_next = count + 1'b1;
          end
          top_next     = ntop[ADDR_BITS-1:0];
          res_off_next = ADDR_BITS'(top + pad);
        end
      end

      S_SCAN_RD: begin
        if (idx == count) begin
          if (rq.req_type == REQ_FREE) begin
            if (count >= FULL) begin
              res_st_next = ST_TABLE_FULL;
              state_next  = S_DONE;
            end else begin
              ins_pos_next  = count;
              ins_word_next = '{start: rq.location, length: rq.block_size};
              j_next        = count;
              state_next    = S_UP_RD;
            end
          end else begin
            state_next = S_BUMP_DIV;
          end
        end else begin
          state_next = S_SCAN_DATA;
        end
      end

      S_SCAN_DATA: begin
        e_start_next = rdata.start;
        e_len_next   = rdata.length;
        if (rq.req_type != REQ_FREE) begin
          div_start  = 1'b1;
          div_dvd    = rdata.start;
          state_next = S_FIT_WAIT;
        end else if (in_end < {1'b0, rdata.start}) begin
          if (count >= FULL) begin
            res_st_next = ST_TABLE_FULL;
            state_next  = S_DONE;
          end else begin
            ins_pos_next  = idx;
            ins_word_next = '{start: rq.location, length: rq.block_size};
            j_next        = count;
            state_next    = S_UP_RD;
          end
        end else if (in_end == {1'b0, rdata.start}) begin
          mem_we     = 1'b1;
          mem_wdata  = '{start: rq.location,
                         length: ADDR_BITS'(rdata.length + rq.block_size)};
          state_next = S_DONE;
        end else if ({1'b0, rq.location} < s_end) begin
          res_st_next = ST_BOGUS_FREE;
          state_next  = S_DONE;
        end else if ({1'b0, rq.location} == s_end) begin
          cur_len_next = ADDR_BITS'(rdata.length + rq.block_size);
          mrg_end_next = in_end;
          if (CNT_W'(idx + 1'b1) < count) begin
            state_next = S_NEXT_RD;
          end else begin
            mem_we     = 1'b1;
            mem_wdata  = '{start: rdata.start,
                           length: ADDR_BITS'(rdata.length + rq.block_size)};
            state_next = S_DONE;
          end
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_SCAN_RD;
        end
      end

      S_FIT_WAIT: begin
        if (div_done) state_next = S_FIT_EVAL;
      end

      S_FIT_EVAL: begin
        res_off_next = ADDR_BITS'(e_start + pad);
        if (need == {1'b0, e_len}) begin
          if (e_len == rq.block_size) begin
            j_next     = idx + 1'b1;
            state_next = S_DN_RD;
          end else begin
            mem_we     = 1'b1;
            mem_wdata  = '{start: e_start, length: ADDR_BITS'(e_len - rq.block_size)};
            state_next = S_DONE;
          end
        end else if (need < {1'b0, e_len}) begin
          if (pad == '0) begin
            mem_we     = 1'b1;
            mem_wdata  = '{start: ADDR_BITS'(e_start + rq.block_size),
                           length: ADDR_BITS'(e_len - rq.block_size)};
            state_next = S_DONE;
          end else if (count >= FULL) begin
            res_off_next = '0;
            res_st_next  = ST_TABLE_FULL;
            state_next   = S_DONE;
          end else begin
            // split: padding stays at idx, the upper part goes in after it
            mem_we        = 1'b1;
            mem_wdata     = '{start: e_start, length: pad};
            ins_pos_next  = idx + 1'b1;
            ins_word_next = '{start: ADDR_BITS'(e_start + pad + rq.block_size),
                              length: ADDR_BITS'(e_len - pad - rq.block_size)};
            j_next        = count;
            state_next    = S_UP_RD;
          end
        end else begin
          res_off_next = '0;
          idx_next     = idx + 1'b1;
          state_next   = S_SCAN_RD;
        end
      end

      S_NEXT_RD: begin
        mem_raddr  = IDX_W'(idx + 1'b1);
        state_next = S_NEXT_DATA;
      end

      S_NEXT_DATA: begin
        mem_we = 1'b1;
        if ({1'b0, rdata.start} == mrg_end) begin
          mem_wdata  = '{start: e_start, length: ADDR_BITS'(cur_len + rdata.length)};
          j_next     = CNT_W'(idx + 2'd2);
          state_next = S_DN_RD;
        end else begin
          mem_wdata  = '{start: e_start, length: cur_len};
          state_next = S_DONE;
        end
      end

      S_UP_RD: begin
        mem_raddr = IDX_W'(j - 1'b1);
        if (j == ins_pos) state_next = S_INS_WR;
        else state_next = S_UP_WR;
      end

      S_UP_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = j[IDX_W-1:0];
        mem_wdata  = rdata;
        j_next     = j - 1'b1;
        state_next = S_UP_RD;
      end

      S_INS_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = ins_pos[IDX_W-1:0];
        mem_wdata  = ins_word;
        count_next = count + 1'b1;
        state_next = S_DONE;
      end

      S_DN_RD: begin
        mem_raddr = j[IDX_W-1:0];
        if (j >= count) begin
          count_next = count - 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_DN_WR;
        end
      end

      S_DN_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = IDX_W'(j - 1'b1);
        mem_wdata  = rdata;
        j_next     = j + 1'b1;
        state_next = S_DN_RD;
      end

      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next = 1'b1;
          rsp_next       = '{offset: (res_st == ST_OK) ? res_off : '0,
                             status: res_st, segment_top: top};
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      top       <= '0;
      cap       <= CAPACITY_RESET;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      top       <= top_next;
      rsp_valid <= rsp_valid_next;
      if (cfg_we) cap <= cfg_data;
    end
    idx      <= idx_next;
    j        <= j_next;
    ins_pos  <= ins_pos_next;
    ins_word <= ins_word_next;
    e_start  <= e_start_next;
    e_len    <= e_len_next;
    cur_len  <= cur_len_next;
    mrg_end  <= mrg_end_next;
    res_off  <= res_off_next;
    res_st   <= res_st_next;
    rq       <= rq_next;
    rsp      <= rsp_next;
  end

endmodule

>>> src/affsa_check.sv
`timescale 1ns / 1ps
module affsa_check (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input affsa_pkg::rsp_t rsp
);
  import affsa_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response beat changed");

  a_err_offset: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.offset == '0)
    else $error("error response carries an offset");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= ST_TABLE_FULL)
    else $error("status code out of range");

  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken before the first finished");

endmodule

bind aligned_first_fit_segment_allocator affsa_check u_affsa_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

>>> verif/aligned_first_fit_segment_allocator_tb.sv
`timescale 1ns / 1ps
module aligned_first_fit_segment_allocator_tb;
  import affsa_pkg::*;

  localparam int NFREE = FREE_ENTRIES_DEF;
  localparam int AMAX  = (1 << ADDR_BITS) - 1;

  logic clk, rst;
  logic cfg_we;
  logic [ADDR_BITS-1:0] cfg_data;
  logic req_valid, req_stall, rsp_valid, rsp_stall;
  req_t req;
  rsp_t rsp;

  aligned_first_fit_segment_allocator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // shadow copy of the allocator state
  int ext_start [NFREE];
  int ext_len   [NFREE];
  int ext_cnt;
  int top_words;
  int cap_words;

  rsp_t pending_rsp [$];
  int   errors;
  int   n_beats, n_ok, n_err, n_rsp;
  bit   quiet;        // no random idling on either side
  int   hold_req;     // bumped to ask the receiver for a long hold-off
  int   hold_seen;
  int   hold_left;

  typedef struct {
    int ofs;
    int sz;
  } blk_t;
  blk_t live [$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int pad_of(int ofs, int al);
    int r;
    r = ofs % al;
    return (r != 0) ? al - r : 0;
  endfunction

  function automatic void ext_insert(int pos, int s, int l);
    for (int j = ext_cnt; j > pos; j--) begin
      ext_start[j] = ext_start[j-1];
      ext_len[j]   = ext_len[j-1];
    end
    ext_start[pos] = s & AMAX;
    ext_len[pos]   = l & AMAX;
    ext_cnt++;
  endfunction

  function automatic void ext_remove(int pos);
    for (int j = pos; j < ext_cnt - 1; j++) begin
      ext_start[j] = ext_start[j+1];
      ext_len[j]   = ext_len[j+1];
    end
    ext_cnt--;
  endfunction

  function automatic logic [2:0] bump_top(int sz, int al, output int res);
    int ofs, pad, nt;
    ofs = top_words;
    pad = pad_of(ofs, al);
    nt  = ofs + pad + sz;
    res = 0;
    if (nt > cap_words || nt > AMAX) return ST_NO_SPACE;
    if (pad != 0 && ext_cnt >= NFREE) return ST_TABLE_FULL;
    // padding goes to the end of the table, no merge with the extent below
    if (pad != 0) ext_insert(ext_cnt, ofs, pad);
    top_words = nt;
    res = ofs + pad;
    return ST_OK;
  endfunction

  function automatic logic [2:0] fit_first(int sz, int al, output int res);
    int ofs, len, pad;
    res = 0;
    for (int i = 0; i < ext_cnt; i++) begin
      ofs = ext_start[i];
      len = ext_len[i];
      pad = pad_of(ofs, al);
      if (sz + pad == len) begin
        ext_len[i] = len - sz;
        if (ext_len[i] == 0) ext_remove(i);
        res = ofs + pad;
        return ST_OK;
      end
      if (sz + pad < len) begin
        if (pad == 0) begin
          ext_start[i] = ofs + sz;
          ext_len[i]   = len - sz;
        end else begin
          if (ext_cnt >= NFREE) return ST_TABLE_FULL;
          ext_insert(i + 1, ofs + pad + sz, len - pad - sz);
          ext_len[i] = pad;
        end
        res = ofs + pad;
        return ST_OK;
      end
    end
    return bump_top(sz, al, res);
  endfunction

  function automatic logic [2:0] give_back(int ofs, int sz);
    int fin, s, e, i;
    fin = ofs + sz;
    if (ofs >= top_words || fin > top_words) return ST_BOGUS_FREE;
    for (i = 0; i < ext_cnt; i++) begin
      s = ext_start[i];
      e = s + ext_len[i];
      if (fin < s) break;
      if (fin == s) begin
        ext_start[i] = ofs;
        ext_len[i]  += sz;
        return ST_OK;
      end
      if (fin > s && ofs < e) return ST_BOGUS_FREE;
      if (ofs == e) begin
        ext_len[i] += sz;
        // closes a hole: fold in the upper neighbor too
        if (i + 1 < ext_cnt && ext_start[i+1] == e + sz) begin
          ext_len[i] += ext_len[i+1];
          ext_remove(i + 1);
        end
        return ST_OK;
      end
    end
    if (ext_cnt >= NFREE) return ST_TABLE_FULL;
    ext_insert(i, ofs, sz);
    return ST_OK;
  endfunction

  function automatic rsp_t alloc_result(req_t r);
    rsp_t o;
    int   res;
    logic [2:0] st;
    res = 0;
    st  = ST_OK;
    case (r.req_type)
      REQ_ALLOC: begin
        if (r.block_size == 0) st = ST_BAD_SIZE;
        else if (r.align == 0) st = ST_BAD_ALIGN;
        else st = fit_first(r.block_size, r.align, res);
      end
      REQ_FREE: begin
        if (r.block_size == 0) st = ST_BAD_SIZE;
        else st = give_back(r.location, r.block_size);
      end
      REQ_HIGH: begin
        if (r.align == 0) st = ST_BAD_ALIGN;
        else st = bump_top(r.block_size, r.align, res);
      end
      default: begin
        ext_cnt   = 0;
        top_words = 0;
      end
    endcase
    if (st != ST_OK) res = 0;
    o.offset      = res[ADDR_BITS-1:0];
    o.status      = st;
    o.segment_top = top_words[ADDR_BITS-1:0];
    return o;
  endfunction

  // ---------------------------------------------------------------- driving
  // Entered and left just after a rising edge. Valid stays high on return so
  // back-to-back beats need no drop in between.
  task automatic send_req(input req_t r, output rsp_t exp_o);
    if (!quiet && $urandom_range(99) < 33) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    exp_o = alloc_result(r);
    pending_rsp.push_back(exp_o);
    n_beats++;
    if (exp_o.status == ST_OK) n_ok++; else n_err++;
  endtask

  task automatic send_fields(logic [1:0] t, int sz, int al, int loc);
    req_t r;
    rsp_t e;
    r.req_type   = t;
    r.block_size = sz[ADDR_BITS-1:0];
    r.align      = al[ADDR_BITS-1:0];
    r.location   = loc[ADDR_BITS-1:0];
    send_req(r, e);
    if (e.status == ST_OK) begin
      if (t == REQ_RESET) live.delete();
      else if (t == REQ_ALLOC || (t == REQ_HIGH && sz != 0))
        live.push_back('{e.offset, sz});
    end
  endtask

  // drop valid and wait for every outstanding response
  task automatic drain();
    int guard;
    req_valid <= 1'b0;
    guard = 0;
    while (pending_rsp.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(int v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v[ADDR_BITS-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    cap_words = v;
    @(posedge clk);
  endtask

  // receiver: random stall, or a long counted hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 600;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !quiet && ($urandom_range(99) < 33);
    end
  end

  // response checker
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      n_rsp++;
      if (pending_rsp.size() == 0) begin
        $error("response beat with nothing pending");
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.offset !== e.offset) begin
          $error("offset: expected %0d, got %0d", e.offset, rsp.offset);
          errors++;
        end
        if (rsp.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, rsp.status);
          errors++;
        end
        if (rsp.segment_top !== e.segment_top) begin
          $error("segment_top: expected %0d, got %0d", e.segment_top, rsp.segment_top);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    send_fields(REQ_ALLOC, 0, 4, 0);            // bad size
    send_fields(REQ_ALLOC, 5, 0, 0);            // bad align
    send_fields(REQ_HIGH, 0, 0, 0);             // high-water, zero align
    send_fields(REQ_HIGH, 0, 1, 0);             // high-water size zero is fine
    send_fields(REQ_FREE, 0, 0, 0);             // free of zero words
    send_fields(REQ_FREE, 4, 0, 0);             // free above the top mark
    send_fields(REQ_HIGH, 3, 1, 0);             // top 3
    send_fields(REQ_ALLOC, 4, 8, 0);            // bump with padding 3..7
    send_fields(REQ_ALLOC, 1, 4, 0);            // pad hole: split at 4
    send_fields(REQ_ALLOC, 3, 1, 0);            // exact fit of remainder
    send_fields(REQ_FREE, 2, 0, 1);             // adjoins the extent at 3, merges into it
    send_fields(REQ_FREE, 2, 0, 2);             // overlaps the one just freed
    send_fields(REQ_FREE, 1, 0, 0);             // merge below
    send_fields(REQ_FREE, 4, 0, 8);             // ends at the top mark, new extent
    send_fields(REQ_FREE, 4, 0, 12);            // ofs at top mark
    send_fields(REQ_ALLOC, AMAX, AMAX, 0);      // out of space
    send_fields(REQ_HIGH, 0, AMAX, AMAX);
    send_fields(REQ_RESET, AMAX, AMAX, AMAX);   // reset ignores its fields
    // fill the table with padding holes (the first bump needs no padding)
    for (int k = 0; k < NFREE + 1; k++) send_fields(REQ_HIGH, 1, 2, 0);
    send_fields(REQ_FREE, 1, 0, 1);             // overlaps a padding hole
    send_fields(REQ_ALLOC, 1, 4, 0);            // bump with padding, full table
    send_fields(REQ_RESET, 0, 0, 0);
  endtask

  task automatic random_beat();
    int pick, k, al;
    blk_t b;
    pick = $urandom_range(99);
    case ($urandom_range(5))
      0: al = 1;
      1: al = 2;
      2: al = 4;
      3: al = 8;
      4: al = $urandom_range(1, 16);
      default: al = ($urandom_range(19) == 0) ? $urandom_range(1, AMAX) : 3;
    endcase
    if (pick < 45) begin
      send_fields(REQ_ALLOC, $urandom_range(1, 48), al, $urandom_range(AMAX));
    end else if (pick < 75 && live.size() != 0) begin
      k = $urandom_range(live.size() - 1);
      b = live[k];
      if ($urandom_range(9) < 8) begin
        send_fields(REQ_FREE, b.sz, $urandom_range(AMAX), b.ofs);
        if (pending_rsp[$].status == ST_OK) live.delete(k);
      end else begin
        send_fields(REQ_FREE, $urandom_range(1, b.sz + 2), 0,
                    b.ofs + $urandom_range(3) - 1);
      end
    end else if (pick < 85) begin
      send_fields(REQ_HIGH, $urandom_range(0, 24), al, 0);
    end else if (pick < 88) begin
      send_fields(REQ_RESET, $urandom_range(AMAX), $urandom_range(AMAX),
                  $urandom_range(AMAX));
    end else begin
      // raw noise over every bit of every field
      send_fields($urandom_range(3), $urandom_range(AMAX), $urandom_range(AMAX),
                  $urandom_range(AMAX));
    end
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) random_beat();
  endtask

  task automatic test_capacity_sweep();
    set_capacity(1);
    send_fields(REQ_HIGH, 1, 1, 0);
    send_fields(REQ_HIGH, 1, 1, 0);               // over capacity
    send_fields(REQ_ALLOC, 1, 1, 0);
    test_random(40);
    set_capacity(300);
    test_random(300);
    set_capacity(AMAX);
    send_fields(REQ_RESET, 0, 0, 0);
    send_fields(REQ_HIGH, AMAX - 1, 1, 0);
    send_fields(REQ_HIGH, 1, 1, 0);               // top at the very end
    send_fields(REQ_ALLOC, 2, 1, 0);
    send_fields(REQ_RESET, 0, 0, 0);
  endtask

  // long receiver hold-off while beats keep coming
  task automatic test_backpressure();
    hold_req <= hold_req + 1;
    test_random(20);
  endtask

  // no idling at all, then a full pause until the block is empty
  task automatic test_streaming();
    quiet = 1'b1;
    test_random(200);
    drain();
    quiet = 1'b0;
  endtask

  initial begin
    int guard;
    errors = 0; n_beats = 0; n_ok = 0; n_err = 0; n_rsp = 0;
    quiet = 1'b0; hold_req = 0;
    ext_cnt = 0; top_words = 0; cap_words = AMAX;
    rst = 1'b1; cfg_we = 1'b0; cfg_data = '0; req_valid = 1'b0; req = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(300);
    test_backpressure();
    test_streaming();
    test_capacity_sweep();
    test_random(300);

    req_valid <= 1'b0;
    guard = 0;
    while (pending_rsp.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (500) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $error("%0d responses never arrived", pending_rsp.size());
    end
    $display("Covered %0d requests (%0d ok, %0d rejected), %0d responses checked,",
             n_beats, n_ok, n_err, n_rsp);
    $display("with capacity sweeps, a long output hold-off and an unthrottled burst.");
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/affsa_pkg.sv
src/affsa_rem.sv
src/aligned_first_fit_segment_allocator.sv
src/affsa_check.sv
verif/aligned_first_fit_segment_allocator_tb.sv
